// File: rtl/apgm_pkg.sv
// Package for the pointer-getter matcher: payload structs, opcode constants,
// status codes and the decoded-instruction record. No dependencies.
package apgm_pkg;

  typedef enum logic [1:0] {
    ST_FETCH  = 2'd0,
    ST_MATCH  = 2'd1,
    ST_REJECT = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  typedef struct packed {
    logic        func;
    logic [63:0] entry_address;
    logic [31:0] instruction;
    logic [31:0] following_instruction;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] fetch_address;
    logic [63:0] found_address;
    logic        loaded_flag;
    logic        indirect_flag;
    logic        has_base_offset;
    logic [63:0] post_load_offset;
    logic        lazy_global_hit;
  } out_item_t;

  typedef enum logic [2:0] {
    K_START,
    K_B,
    K_ADR,
    K_ADDI,
    K_LDR,
    K_RET,
    K_NOP,
    K_BAD
  } kind_t;

  // Classified item passed from the front end to the execute stage.
  typedef struct packed {
    kind_t       kind;
    logic [63:0] entry;
    logic [4:0]  rd;
    logic [4:0]  rn;
    logic        page;
    logic [20:0] adr_imm;
    logic [25:0] b_imm;
    logic [23:0] addi_imm;
    logic [14:0] ldr_off;
    logic        nw_ok;
    logic        nw_is_ret;
  } dec_t;

  localparam logic [31:0] OP_B     = 32'h14000000;
  localparam logic [31:0] OP_ADRP  = 32'h90000000;
  localparam logic [31:0] OP_ADR   = 32'h10000000;
  localparam logic [31:0] OP_ADDI  = 32'h91000000;
  localparam logic [31:0] OP_LDR   = 32'hf9400000;
  localparam logic [31:0] OP_RET   = 32'hd65f03c0;
  localparam logic [31:0] OP_CBNZ  = 32'hb5000000;
  localparam logic [31:0] OP_STP   = 32'h290003e0;
  localparam logic [31:0] OP_FRAME = 32'h910003fd;
  localparam logic [31:0] OP_STR   = 32'hf80003e0;
  localparam logic [31:0] OP_BTI   = 32'hd503245f;
  localparam logic [31:0] OP_PACI  = 32'hd503233f;
  localparam logic [31:0] OP_PACIB = 32'hd503237f;
  localparam logic [31:0] OP_NOP   = 32'hd503201f;

endpackage

// File: rtl/aarch64_pointer_getter_matcher.sv
// AArch64 pointer-getter matcher, top level.
// Path from input transfer to result: decode queue, operand registers, writeback register.
// The execute stage takes no new item until the previous one is written back, since
// it runs a read/writeback loop on the symbolic register file and program counter.
// Reset (rst, synchronous): walk idle, counters and register valid bits clear.
// Depends on apgm_pkg, apgm_decode, apgm_exec.
module aarch64_pointer_getter_matcher import apgm_pkg::*; #(
  parameter int STEP_LIMIT   = 32,
  parameter int BRANCH_LIMIT = 4,
  parameter int ADDR_BITS    = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic q_valid, q_ready;
  dec_t q_data;

  apgm_decode #(.ADDR_BITS(ADDR_BITS)) u_dec (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  apgm_exec #(
    .STEP_LIMIT(STEP_LIMIT), .BRANCH_LIMIT(BRANCH_LIMIT), .ADDR_BITS(ADDR_BITS)
  ) u_exec (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

// File: rtl/apgm_decode.sv
// Front end: classifies each accepted item into a dec_t record and pushes it
// into a two-entry queue. Depends on apgm_pkg.
module apgm_decode import apgm_pkg::*; #(
  parameter int ADDR_BITS = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output dec_t     q_data
);

  dec_t       d;
  logic [31:0] w, nw;
  dec_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  always_comb begin
    w  = in_data.instruction;
    nw = in_data.following_instruction;
    d = '0;
    d.entry = '0;
    d.entry[ADDR_BITS-1:0] = in_data.entry_address[ADDR_BITS-1:0];
    d.rd = w[4:0];
    d.rn = w[9:5];
    d.page = w[31];
    d.adr_imm = {w[23:5], w[30:29]};
    d.b_imm = w[25:0];
    d.addi_imm = w[22] ? {w[21:10], 12'd0} : {12'd0, w[21:10]};
    d.ldr_off = {w[21:10], 3'd0};
    d.nw_ok = ((nw & 32'hff00001f) == OP_CBNZ) || (nw == OP_RET);
    d.nw_is_ret = nw == OP_RET;
    if (!in_data.func)
      d.kind = K_START;
    else if ((w & 32'hfc000000) == OP_B)
      d.kind = K_B;
    else if ((w & 32'h9f000000) == OP_ADRP || (w & 32'h9f000000) == OP_ADR)
      d.kind = K_ADR;
    else if ((w & 32'hff800000) == OP_ADDI)
      d.kind = K_ADDI;
    else if ((w & 32'hffc00000) == OP_LDR)
      d.kind = K_LDR;
    else if (w == OP_RET)
      d.kind = K_RET;
    else if (w == OP_BTI || w == OP_PACI || w == OP_PACIB || w == OP_NOP ||
             (w & 32'h3b4003e0) == OP_STP || (w & 32'hffe003e0) == OP_STR ||
             w == OP_FRAME)
      d.kind = K_NOP;
    else
      d.kind = K_BAD;
  end

  // RET with X0 unknown falls back to the generic reject in the back end.
  assign in_ready = cnt != 2'd2;
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;
  assign q_valid = cnt != 2'd0;
  assign q_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= d;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/apgm_exec.sv
// Back end: symbolic register file, counters and the execute
// sequence (operand read/add, then writeback and result). Depends on apgm_pkg.
module apgm_exec import apgm_pkg::*; #(
  parameter int STEP_LIMIT   = 32,
  parameter int BRANCH_LIMIT = 4,
  parameter int ADDR_BITS    = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  dec_t      q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int RN = 31;

  typedef enum logic { S_RD, S_WB } phase_t;

  phase_t      phase;
  logic        active;
  logic [63:0] pc;
  logic [5:0]  step_count;
  logic [2:0]  branch_count;
  logic [RN-1:0] reg_valid, reg_loaded;
  logic [63:0] reg_address [RN];
  logic [63:0] reg_offset  [RN];

  // stage registers
  dec_t        k;
  logic        s_valid, s_loaded;
  logic [63:0] s_addr, s_off;
  logic [64:0] sum_a;     // main add
  logic        sum_bad;   // under/overflow of the main add
  logic [64:0] pc4;

  logic [63:0] amask;
  assign amask = (ADDR_BITS == 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);

  function automatic logic over(input logic [64:0] s, input logic [63:0] m);
    over = s[64] || ((s[63:0] & ~m) != 64'd0);
  endfunction

  // operand selection (read phase)
  logic        rv, rl;
  logic [63:0] ra, ro, base, addend;
  logic        sub;
  logic [63:0] mag;
  always_comb begin
    rv = (q_data.rn != 5'd31) && reg_valid[q_data.rn];
    rl = (q_data.rn != 5'd31) && reg_loaded[q_data.rn];
    ra = (q_data.rn != 5'd31) ? reg_address[q_data.rn] : 64'd0;
    ro = (q_data.rn != 5'd31) ? reg_offset[q_data.rn] : 64'd0;
    base = pc; addend = 64'd0; sub = 1'b0; mag = 64'd0;
    case (q_data.kind)
      K_B: begin
        sub = q_data.b_imm[25];
        mag = sub ? {36'd0, 26'(-q_data.b_imm), 2'd0} : 64'd0;
        addend = {36'd0, q_data.b_imm, 2'd0};
      end
      K_ADR: begin
        base = q_data.page ? {pc[63:12], 12'd0} : pc;
        sub = q_data.adr_imm[20];
        mag = q_data.page ? {31'd0, 21'(-q_data.adr_imm), 12'd0} :
                            {43'd0, 21'(-q_data.adr_imm)};
        addend = q_data.page ? {31'd0, q_data.adr_imm, 12'd0} : {43'd0, q_data.adr_imm};
      end
      K_ADDI: begin base = rl ? ro : ra; addend = {40'd0, q_data.addi_imm}; end
      K_LDR:  begin base = rl ? ro : ra; addend = {49'd0, q_data.ldr_off}; end
      default: ;
    endcase
  end

  logic [64:0] add_c;
  logic        bad_c;
  always_comb begin
    if (sub) begin
      add_c = {1'b0, base - mag};
      bad_c = mag > base;
    end else begin
      add_c = {1'b0, base} + {1'b0, addend};
      bad_c = over(add_c, amask);
    end
  end

  logic active_ready;
  assign active_ready = (phase == S_RD) && (!out_valid || out_ready);
  assign q_ready = active_ready;

  // result (writeback phase)
  out_item_t   r;
  logic        rej, fin, do_pc4;
  logic [63:0] new_pc;
  logic        wr_reg, wr_clr;
  logic        w_valid, w_loaded;
  logic [63:0] w_addr, w_off;
  logic        ret_val;
  always_comb begin
    r = '0;
    rej = 1'b0; fin = 1'b0; do_pc4 = 1'b1;
    new_pc = pc;
    wr_reg = 1'b0; wr_clr = 1'b0;
    w_valid = 1'b1; w_loaded = 1'b0; w_addr = sum_a[63:0]; w_off = 64'd0;
    ret_val = (k.rd == 5'd0) && !over(pc4, amask) && k.nw_ok;
    case (k.kind)
      K_B: begin
        do_pc4 = 1'b0;
        if (branch_count >= 3'(BRANCH_LIMIT) || sum_bad) rej = 1'b1;
        else begin new_pc = sum_a[63:0]; wr_clr = 1'b1; end
      end
      K_ADR: begin
        if (k.rd == 5'd31 || sum_bad) rej = 1'b1;
        else wr_reg = 1'b1;
      end
      K_ADDI: begin
        if (k.rd != 5'd31 && k.rn != 5'd31 && s_valid) begin
          if (sum_bad) rej = 1'b1;
          else begin
            wr_reg = 1'b1; w_loaded = s_loaded;
            w_addr = s_loaded ? s_addr : sum_a[63:0];
            w_off  = s_loaded ? sum_a[63:0] : s_off;
          end
        end else if (k.rd != 5'd31) begin
          wr_reg = 1'b1; w_valid = 1'b0;
          w_addr = s_addr; w_off = s_off;
        end
      end
      K_LDR: begin
        if (k.rd == 5'd31 || k.rn == 5'd31 || !s_valid) rej = 1'b1;
        else if (s_loaded) begin
          if (ret_val && !sum_bad) begin
            fin = 1'b1;
            r.status = ST_MATCH; r.found_address = s_addr; r.loaded_flag = 1'b1;
            r.indirect_flag = !k.nw_is_ret; r.has_base_offset = 1'b1;
            r.post_load_offset = sum_a[63:0];
          end else rej = 1'b1;
        end else if (sum_bad) rej = 1'b1;
        else if (ret_val) begin
          fin = 1'b1;
          r.status = ST_MATCH; r.found_address = sum_a[63:0]; r.loaded_flag = 1'b1;
          r.indirect_flag = !k.nw_is_ret;
          r.lazy_global_hit = !k.nw_is_ret;
        end else begin
          wr_reg = 1'b1; w_loaded = 1'b1;
        end
      end
      K_RET: begin
        if (reg_valid[0]) begin
          fin = 1'b1;
          r.status = ST_MATCH; r.found_address = reg_address[0];
          r.has_base_offset = reg_loaded[0];
          r.post_load_offset = reg_loaded[0] ? reg_offset[0] : 64'd0;
        end else rej = 1'b1;
      end
      K_NOP: ;
      default: rej = 1'b1;
    endcase
    if (!rej && !fin && do_pc4) begin
      if (over(pc4, amask)) rej = 1'b1;
      else new_pc = pc4[63:0];
    end
    if (!rej && !fin) begin
      if (step_count + 6'd1 >= 6'(STEP_LIMIT)) rej = 1'b1;
      else begin r.status = ST_FETCH; r.fetch_address = new_pc; end
    end
    if (rej) r = '{status: ST_REJECT, default: '0};
  end

  logic take;
  assign take = q_valid && active_ready;

  always_ff @(posedge clk) begin
    if (take) begin
      k <= q_data;
      s_valid <= rv; s_loaded <= rl; s_addr <= ra; s_off <= ro;
      sum_a <= add_c; sum_bad <= bad_c;
      pc4 <= {1'b0, pc} + 65'd4;
    end
    if (phase == S_WB && k.kind != K_START && active && !rej && !fin && wr_reg) begin
      reg_address[k.rd] <= w_addr;
      reg_offset[k.rd]  <= w_loaded ? w_off : (k.kind == K_ADDI ? w_off : 64'd0);
    end
    if (rst) begin
      phase <= S_RD; active <= 1'b0; pc <= 64'd0; step_count <= 6'd0;
      branch_count <= 3'd0; reg_valid <= '0; reg_loaded <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take) phase <= S_WB;
      if (phase == S_WB) begin
        phase <= S_RD;
        out_valid <= 1'b1;
        if (k.kind == K_START) begin
          reg_valid <= '0; reg_loaded <= '0;
          step_count <= 6'd0; branch_count <= 3'd0;
          pc <= k.entry;
          active <= k.entry[1:0] == 2'b00;
          out_data <= (k.entry[1:0] != 2'b00) ? '{status: ST_REJECT, default: '0} :
                      '{status: ST_FETCH, fetch_address: k.entry, default: '0};
        end else if (!active) begin
          out_data <= '{status: ST_IDLE, default: '0};
        end else begin
          out_data <= r;
          if (k.kind == K_B && branch_count < 3'(BRANCH_LIMIT))
            branch_count <= branch_count + 3'd1;
          if (rej) active <= 1'b0;
          else if (!fin) begin
            pc <= new_pc;
            step_count <= step_count + 6'd1;
            if (wr_clr) begin reg_valid <= '0; reg_loaded <= '0; end
            if (wr_reg) begin
              reg_valid[k.rd]  <= w_valid;
              reg_loaded[k.rd] <= w_valid ? w_loaded : 1'b0;
            end
          end
        end
      end
    end
  end

endmodule

// File: bench/tb_aarch64_pointer_getter_matcher.sv
// Self-checking bench for aarch64_pointer_getter_matcher: a behavioural matcher
// predicts every result, a queue-fed driver and a monitor check the transfers.
// Depends on apgm_pkg and the RTL top level.
module tb_aarch64_pointer_getter_matcher;
  import apgm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS_MAX    = 32;
  localparam int BRANCHES_MAX = 4;
  localparam int WATCHDOG     = 20000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  aarch64_pointer_getter_matcher u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state
  logic        walk_on;
  logic [63:0] pc_q;
  int          steps;
  int          branches;
  logic        sym_valid [31];
  logic        sym_loaded [31];
  logic [63:0] sym_addr [31];
  logic [63:0] sym_off [31];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        errors;
  int        idle_pct;
  int        quiet_cycles;
  logic      hold_send;
  logic      in_taken;   // current item already transferred

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void wipe_regs();
    for (int i = 0; i < 31; i++) begin
      sym_valid[i] = 1'b0;
      sym_loaded[i] = 1'b0;
      sym_addr[i] = '0;
      sym_off[i] = '0;
    end
  endfunction

  function automatic bit sum_ok(input logic [63:0] a, input logic [63:0] b,
                                output logic [63:0] r);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    r = s[63:0];
    return !s[64];
  endfunction

  // base plus sign-extended field shifted left, no wrap either way
  function automatic bit disp_ok(input logic [63:0] base, input logic [63:0] field,
                                 input int bits, input int sh, output logic [63:0] r);
    logic [63:0] mag;
    r = '0;
    if (field[bits-1]) begin
      mag = ((64'd1 << bits) - field) << sh;
      if (mag > base) return 0;
      r = base - mag;
      return 1;
    end
    return sum_ok(base, field << sh, r);
  endfunction

  function automatic out_item_t make_result(input status_t st, input logic [63:0] fetch,
      input logic [63:0] found, input logic ld, input logic ind, input logic ho,
      input logic [63:0] off);
    out_item_t o;
    o.status = st;
    o.fetch_address = (st == ST_FETCH) ? fetch : 64'd0;
    o.found_address = found;
    o.loaded_flag = ld;
    o.indirect_flag = ind;
    o.has_base_offset = ho;
    o.post_load_offset = off;
    o.lazy_global_hit = ld & ind & ~ho;
    if (st != ST_FETCH && st != ST_MATCH) walk_on = 1'b0;
    return o;
  endfunction

  function automatic out_item_t walk_step(input in_item_t it);
    logic [31:0] w, nw;
    logic [4:0]  rd, rn;
    logic [63:0] t, nx, a, o, imm, off;
    logic        ld, retv, ind, page;
    out_item_t   rej;
    rej = '0;
    rej.status = ST_REJECT;
    if (!it.func) begin
      wipe_regs();
      steps = 0;
      branches = 0;
      pc_q = it.entry_address;
      walk_on = 1'b0;
      if (it.entry_address[1:0] != 2'b00) return rej;
      walk_on = 1'b1;
      return make_result(ST_FETCH, pc_q, 0, 0, 0, 0, 0);
    end
    if (!walk_on) return make_result(ST_IDLE, 0, 0, 0, 0, 0, 0);
    w = it.instruction;
    nw = it.following_instruction;
    rd = w[4:0];
    rn = w[9:5];
    if ((w & 32'hfc000000) == OP_B) begin
      if (branches >= BRANCHES_MAX) begin walk_on = 0; return rej; end
      branches++;
      if (!disp_ok(pc_q, {38'd0, w[25:0]}, 26, 2, t)) begin walk_on = 0; return rej; end
      wipe_regs();
      pc_q = t;
    end else begin
      if ((w & 32'h9f000000) == OP_ADRP || (w & 32'h9f000000) == OP_ADR) begin
        page = w[31];
        imm = {43'd0, w[23:5], w[30:29]};
        if (rd == 5'd31) begin walk_on = 0; return rej; end
        if (!disp_ok(page ? (pc_q & ~64'd4095) : pc_q, imm, 21, page ? 12 : 0, t)) begin
          walk_on = 0;
          return rej;
        end
        sym_valid[rd] = 1; sym_loaded[rd] = 0; sym_addr[rd] = t; sym_off[rd] = 0;
      end else if ((w & 32'hff800000) == OP_ADDI) begin
        if (rd != 31 && rn != 31 && sym_valid[rn]) begin
          imm = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
          ld = sym_loaded[rn];
          a = sym_addr[rn];
          o = sym_off[rn];
          if (!sum_ok(ld ? o : a, imm, t)) begin walk_on = 0; return rej; end
          if (ld) o = t; else a = t;
          sym_valid[rd] = 1; sym_loaded[rd] = ld; sym_addr[rd] = a; sym_off[rd] = o;
        end else if (rd != 31) begin
          sym_valid[rd] = 0;
          sym_loaded[rd] = 0;
        end
      end else if ((w & 32'hffc00000) == OP_LDR) begin
        if (rd == 31 || rn == 31 || !sym_valid[rn]) begin walk_on = 0; return rej; end
        off = {49'd0, w[21:10], 3'd0};
        retv = rd == 0 && sum_ok(pc_q, 4, nx) &&
               ((nw & 32'hff00001f) == OP_CBNZ || nw == OP_RET);
        ind = nw != OP_RET;
        if (sym_loaded[rn]) begin
          if (retv && sum_ok(sym_off[rn], off, t))
            return make_result(ST_MATCH, 0, sym_addr[rn], 1, ind, 1, t);
          walk_on = 0;
          return rej;
        end
        if (!sum_ok(sym_addr[rn], off, t)) begin walk_on = 0; return rej; end
        if (retv) return make_result(ST_MATCH, 0, t, 1, ind, 0, 0);
        sym_valid[rd] = 1; sym_loaded[rd] = 1; sym_addr[rd] = t; sym_off[rd] = 0;
      end else if (w == OP_RET && sym_valid[0]) begin
        ld = sym_loaded[0];
        return make_result(ST_MATCH, 0, sym_addr[0], 0, 0, ld, ld ? sym_off[0] : 0);
      end else if (!(w == OP_BTI || w == OP_PACI || w == OP_PACIB || w == OP_NOP ||
                     (w & 32'h3b4003e0) == OP_STP || (w & 32'hffe003e0) == OP_STR ||
                     w == OP_FRAME)) begin
        walk_on = 0;
        return rej;
      end
      if (!sum_ok(pc_q, 4, t)) begin walk_on = 0; return rej; end
      pc_q = t;
    end
    steps++;
    if (steps >= STEPS_MAX) begin walk_on = 0; return rej; end
    return make_result(ST_FETCH, pc_q, 0, 0, 0, 0, 0);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // item builders
  function automatic in_item_t start_at(input logic [63:0] a);
    in_item_t it;
    it = '0;
    it.func = 1'b0;
    it.entry_address = a;
    it.instruction = $urandom;
    it.following_instruction = $urandom;
    return it;
  endfunction

  function automatic in_item_t insn(input logic [31:0] w, input logic [31:0] nw);
    in_item_t it;
    it.func = 1'b1;
    it.entry_address = {$urandom, $urandom};
    it.instruction = w;
    it.following_instruction = nw;
    return it;
  endfunction

  function automatic logic [31:0] enc_adr(input bit page, input logic [20:0] imm,
                                          input logic [4:0] rd);
    return (page ? OP_ADRP : OP_ADR) | {1'b0, imm[1:0], 5'd0, imm[20:2], rd};
  endfunction

  function automatic logic [31:0] enc_addi(input bit sh, input logic [11:0] imm,
                                           input logic [4:0] rn, input logic [4:0] rd);
    return OP_ADDI | {9'd0, sh, imm, rn, rd};
  endfunction

  function automatic logic [31:0] enc_ldr(input logic [11:0] imm, input logic [4:0] rn,
                                          input logic [4:0] rd);
    return OP_LDR | {10'd0, imm, rn, rd};
  endfunction

  function automatic logic [31:0] tail_word();
    case ($urandom_range(0, 3))
      0: return OP_RET;
      1: return OP_CBNZ | {8'd0, 19'($urandom), 5'd0};
      2: return OP_CBNZ | {8'd0, 19'($urandom), 5'($urandom_range(1, 31))};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] filler();
    case ($urandom_range(0, 6))
      0: return OP_BTI;
      1: return OP_PACI;
      2: return OP_PACIB;
      3: return OP_NOP;
      4: return OP_FRAME;
      5: return OP_STP | ($urandom & ~32'h3b4003e0 & ~32'h000003e0) | {27'd0, 5'($urandom)};
      default: return OP_STR | ($urandom & 32'h001ffc1f);
    endcase
  endfunction

  function automatic logic [63:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 64'hffff_ffff_ffff_fff0 + 4 * $urandom_range(0, 3);
      1: return {52'd0, 10'($urandom), 2'b00};
      2: return {$urandom, $urandom};
      default: return {32'h0000_0000, $urandom} & ~64'd3;
    endcase
  endfunction

  // a mostly well-formed getter body with random content
  task automatic queue_walk();
    int n;
    logic [4:0] r, r2;
    pending_items.push_back(start_at(rand_entry()));
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      r = 5'($urandom_range(0, 4));
      r2 = 5'($urandom_range(0, 4));
      case ($urandom_range(0, 9))
        0, 1: pending_items.push_back(insn(enc_adr($urandom_range(0, 1), 21'($urandom), r),
                                           $urandom));
        2, 3: pending_items.push_back(insn(enc_addi($urandom_range(0, 1), 12'($urandom),
                                                    r2, r), $urandom));
        4: pending_items.push_back(insn(enc_ldr(12'($urandom), r2, r), tail_word()));
        5: pending_items.push_back(insn(OP_B | {6'd0, 26'($urandom_range(0, 8))}, $urandom));
        6: pending_items.push_back(insn($urandom, $urandom));
        7: pending_items.push_back(insn(filler(), $urandom));
        default: pending_items.push_back(insn(filler(), $urandom));
      endcase
    end
    case ($urandom_range(0, 3))
      0: pending_items.push_back(insn(OP_RET, $urandom));
      1: begin
        pending_items.push_back(insn(enc_adr(1, 21'($urandom), 5'd1), $urandom));
        pending_items.push_back(insn(enc_ldr(12'($urandom), 5'd1, 5'd0), tail_word()));
      end
      2: begin
        pending_items.push_back(insn(enc_adr($urandom_range(0, 1), 21'($urandom), 5'd2),
                                     $urandom));
        pending_items.push_back(insn(enc_ldr(12'($urandom), 5'd2, 5'd2), $urandom));
        pending_items.push_back(insn(enc_addi($urandom_range(0, 1), 12'($urandom), 5'd2, 5'd2),
                                     $urandom));
        pending_items.push_back(insn(enc_ldr(12'($urandom), 5'd2, 5'd0), tail_word()));
      end
      default: pending_items.push_back(insn(enc_adr(0, 21'($urandom), 5'd0), OP_RET));
    endcase
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_taken) begin
        // hold the item until taken
      end else if (!hold_send && pending_items.size() != 0 &&
                   $urandom_range(0, 99) >= idle_pct) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        in_taken = 1'b0;
      end else begin
        in_valid <= 1'b0;
        in_taken = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (in_valid && in_ready) begin
        expected_results.push_back(walk_step(in_data));
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data.status, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status != want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.fetch_address != want.fetch_address)
            report_mismatch("fetch_address", out_data.fetch_address, want.fetch_address);
          if (out_data.found_address != want.found_address)
            report_mismatch("found_address", out_data.found_address, want.found_address);
          if (out_data.loaded_flag != want.loaded_flag)
            report_mismatch("loaded_flag", out_data.loaded_flag, want.loaded_flag);
          if (out_data.indirect_flag != want.indirect_flag)
            report_mismatch("indirect_flag", out_data.indirect_flag, want.indirect_flag);
          if (out_data.has_base_offset != want.has_base_offset)
            report_mismatch("has_base_offset", out_data.has_base_offset,
                            want.has_base_offset);
          if (out_data.post_load_offset != want.post_load_offset)
            report_mismatch("post_load_offset", out_data.post_load_offset,
                            want.post_load_offset);
          if (out_data.lazy_global_hit != want.lazy_global_hit)
            report_mismatch("lazy_global_hit", out_data.lazy_global_hit,
                            want.lazy_global_hit);
        end
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("[aarch64_pointer_getter_matcher] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int remaining;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    errors = 0;
    idle_pct = 33;
    quiet_cycles = 0;
    hold_send = 1'b0;
    in_taken = 1'b0;
    walk_on = 1'b0;
    pc_q = '0;
    steps = 0;
    branches = 0;
    wipe_regs();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: idle item, misaligned entry, every accepted opcode class, limits
    pending_items.push_back(insn(OP_RET, OP_RET));
    pending_items.push_back(start_at(64'h1002));
    pending_items.push_back(insn(OP_NOP, 0));
    pending_items.push_back(start_at(64'h0000_0000_0040_1000));
    pending_items.push_back(insn(OP_BTI, 0));
    pending_items.push_back(insn(OP_FRAME, 0));
    pending_items.push_back(insn(enc_adr(1, 21'h1fffff, 5'd3), 0));
    pending_items.push_back(insn(enc_addi(1, 12'hfff, 5'd3, 5'd0), 0));
    pending_items.push_back(insn(OP_RET, 0));
    pending_items.push_back(start_at(64'h2000));
    pending_items.push_back(insn(enc_adr(0, 21'h000fff, 5'd4), 0));
    pending_items.push_back(insn(enc_ldr(12'hfff, 5'd4, 5'd4), 0));
    pending_items.push_back(insn(enc_ldr(12'h001, 5'd4, 5'd0), OP_CBNZ));
    pending_items.push_back(start_at(64'hffff_ffff_ffff_fffc));
    pending_items.push_back(insn(enc_adr(0, 21'h0, 5'd0), 0));
    pending_items.push_back(start_at(64'hffff_ffff_ffff_fff8));
    pending_items.push_back(insn(enc_adr(0, 21'h0, 5'd1), 0));
    pending_items.push_back(insn(enc_ldr(12'h0, 5'd1, 5'd0), OP_RET));
    pending_items.push_back(start_at(64'h0));
    pending_items.push_back(insn(OP_B | 32'h03ffffff, 0));
    pending_items.push_back(start_at(64'h100));
    for (int i = 0; i < 5; i++) pending_items.push_back(insn(OP_B, 0));
    pending_items.push_back(start_at(64'h100));
    for (int i = 0; i < 32; i++) pending_items.push_back(insn(OP_NOP, 0));
    pending_items.push_back(insn(enc_addi(0, 12'h0, 5'd31, 5'd0), 0));
    wait_drained();

    // one stretch with no idling
    idle_pct = 0;
    for (int i = 0; i < 30; i++) queue_walk();
    wait_drained();
    idle_pct = 33;

    remaining = 1260;
    while (remaining > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back($urandom_range(0, 1) ? start_at({$urandom, $urandom})
                                                     : insn($urandom, $urandom));
        remaining--;
      end else begin
        queue_walk();
        remaining -= 6;
      end
      if (pending_items.size() > 40) begin
        while (pending_items.size() > 8) @(posedge clk);
      end
    end
    // sender holds off until everything has come back
    hold_send = 1'b1;
    while (expected_results.size() != 0 || in_valid) @(posedge clk);
    hold_send = 1'b0;
    for (int i = 0; i < 10; i++) queue_walk();
    wait_drained();

    if (errors == 0) begin
      $display("[aarch64_pointer_getter_matcher] OK");
    end else begin
      $display("[aarch64_pointer_getter_matcher] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/apgm_pkg.sv
rtl/apgm_decode.sv
rtl/apgm_exec.sv
rtl/aarch64_pointer_getter_matcher.sv
bench/tb_aarch64_pointer_getter_matcher.sv
